// ----- rtl/hdup_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hdup_pkg
// Shared types, constants and tables of the HTTP date to Unix time parser.
// ============================================================================
package hdup_pkg;

    localparam int unsigned C_QUEUE_DEPTH = 4;
    localparam int unsigned C_MAX_YEAR    = 9999;
    localparam int unsigned W_CHAR        = 8;
    localparam int unsigned W_SECONDS     = 38;

    // One parsed string, handed from the parser to the converter.
    typedef struct packed {
        logic        date_ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date_rec;

    localparam logic [23:0] C_MONTH_NAMES [12] = '{
        24'h6a616e, 24'h666562, 24'h6d6172, 24'h617072, 24'h6d6179, 24'h6a756e,
        24'h6a756c, 24'h617567, 24'h736570, 24'h6f6374, 24'h6e6f76, 24'h646563
    };

    // Days of a common year that lie before the first of each month.
    localparam logic [8:0] C_CUM_DAYS [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
    };

    function automatic logic [3:0] month_lookup(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] d);
        logic [3:0] res;
        res = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (C_MONTH_NAMES[i] == {a, b, d}) begin
                res = 4'(i + 1);
            end
        end
        return res;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] month);
        return C_CUM_DAYS[month];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/hdup_char_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hdup_char_if
// Character channel: one string character per transaction.
// ============================================================================
interface hdup_char_if;
    logic                          valid;
    logic                          ready;
    logic [hdup_pkg::W_CHAR-1:0]   char_byte;
    logic                          last_char;

    modport source(output valid, output char_byte, output last_char, input ready);
    modport sink(input valid, input char_byte, input last_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/hdup_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hdup_result_if
// Result channel: one converted date per transaction.
// ============================================================================
interface hdup_result_if;
    logic                            valid;
    logic                            ready;
    logic                            date_valid;
    logic [hdup_pkg::W_SECONDS-1:0]  unix_seconds;

    modport source(output valid, output date_valid, output unix_seconds, input ready);
    modport sink(input valid, input date_valid, input unix_seconds, output ready);
endinterface
`default_nettype wire

// ----- rtl/hdup_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hdup_front
// Character parser: walks the date syntax one character per cycle while the
// record queue has room, and emits one checked record per string.
// ============================================================================
module hdup_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hdup_char_if.sink          i_char,
    input  wire logic          i_full,
    output logic               o_push,
    output hdup_pkg::t_date_rec o_rec
);

    localparam logic [3:0] PH_SKIP      = 4'd0;
    localparam logic [3:0] PH_DAY_LEAD  = 4'd1;
    localparam logic [3:0] PH_DAY_DIG   = 4'd2;
    localparam logic [3:0] PH_MON0      = 4'd3;
    localparam logic [3:0] PH_MON1      = 4'd4;
    localparam logic [3:0] PH_MON2      = 4'd5;
    localparam logic [3:0] PH_YEAR_LEAD = 4'd6;
    localparam logic [3:0] PH_YEAR_DIG  = 4'd7;
    localparam logic [3:0] PH_HOUR_LEAD = 4'd8;
    localparam logic [3:0] PH_HOUR_DIG  = 4'd9;
    localparam logic [3:0] PH_MIN_LEAD  = 4'd10;
    localparam logic [3:0] PH_MIN_DIG   = 4'd11;
    localparam logic [3:0] PH_SEC_LEAD  = 4'd12;
    localparam logic [3:0] PH_SEC_DIG   = 4'd13;
    localparam logic [3:0] PH_DONE      = 4'd14;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_CASE    = 8'h20;

    localparam logic [10:0] ACC7_MAX  = 11'd127;
    localparam logic [17:0] ACC14_MAX = 18'd16383;

    function automatic logic [7:0] add7(input logic [6:0] acc, input logic [7:0] c);
        logic [10:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, c[3:0]};
        if (v > ACC7_MAX) begin
            return {1'b1, 7'h7f};
        end
        return {1'b0, v[6:0]};
    endfunction

    function automatic logic [14:0] add14(input logic [13:0] acc, input logic [7:0] c);
        logic [17:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {14'd0, c[3:0]};
        if (v > ACC14_MAX) begin
            return {1'b1, 14'h3fff};
        end
        return {1'b0, v[13:0]};
    endfunction

    logic [3:0]  r_phase, n_phase;
    logic [6:0]  r_day, n_day;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_min, n_min;
    logic [6:0]  r_sec, n_sec;
    logic [7:0]  r_mon0, n_mon0;
    logic [7:0]  r_mon1, n_mon1;
    logic [3:0]  r_month, n_month;
    logic        r_taken, n_taken;
    logic        r_minus, n_minus;
    logic        r_fail, n_fail;

    logic        w_take;
    logic [7:0]  w_c;
    logic [7:0]  w_lc;
    logic        w_ws;
    logic        w_dig;
    logic        w_sign;
    logic        w_end;
    logic        w_ok;
    logic [7:0]  w_add_day, w_add_hour, w_add_min, w_add_sec;
    logic [14:0] w_add_year;

    assign i_char.ready = !i_full;
    assign w_take = i_char.valid && i_char.ready;
    assign w_c    = i_char.char_byte;
    assign w_lc   = (w_c >= CH_UPPER_A && w_c <= CH_UPPER_Z) ? (w_c + CH_CASE) : w_c;
    assign w_ws   = (w_c == CH_SPACE) || (w_c == CH_TAB) || (w_c == CH_CR) || (w_c == CH_LF);
    assign w_dig  = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_sign = (w_c == CH_PLUS) || (w_c == CH_MINUS);
    assign w_add_day  = add7(r_day, w_c);
    assign w_add_hour = add7(r_hour, w_c);
    assign w_add_min  = add7(r_min, w_c);
    assign w_add_sec  = add7(r_sec, w_c);
    assign w_add_year = add14(r_year, w_c);
    assign o_push = w_take && i_char.last_char;

    always_comb begin
        n_phase = r_phase;
        n_day   = r_day;
        n_year  = r_year;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_mon0  = r_mon0;
        n_mon1  = r_mon1;
        n_month = r_month;
        n_taken = r_taken;
        n_minus = r_minus;
        n_fail  = r_fail;
        w_end   = 1'b0;

        if (w_take && !r_fail && r_phase != PH_DONE) begin
            if (w_c == CH_NUL) begin
                w_end = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_SKIP: begin
                        if (w_c == CH_COMMA) n_phase = PH_DAY_LEAD;
                    end
                    PH_DAY_LEAD: begin
                        if (w_dig) begin
                            {n_fail, n_day} = w_add_day;
                            n_phase = PH_DAY_DIG;
                        end else if (w_sign) begin
                            n_minus = (w_c == CH_MINUS);
                            n_phase = PH_DAY_DIG;
                        end else if (!w_ws) begin
                            n_fail = 1'b1;
                        end
                    end
                    PH_DAY_DIG: begin
                        if (w_dig) begin
                            {n_fail, n_day} = w_add_day;
                        end else begin
                            n_fail  = r_minus && (r_day != 7'd0);
                            n_minus = 1'b0;
                            n_taken = 1'b0;
                            n_phase = PH_MON0;
                            if (!n_fail && !w_ws) begin
                                n_mon0  = w_lc;
                                n_phase = PH_MON1;
                            end
                        end
                    end
                    PH_MON0: begin
                        if (!w_ws) begin
                            n_mon0  = w_lc;
                            n_phase = PH_MON1;
                        end
                    end
                    PH_MON1: begin
                        n_mon1  = w_lc;
                        n_phase = PH_MON2;
                    end
                    PH_MON2: begin
                        n_month = hdup_pkg::month_lookup(r_mon0, r_mon1, w_lc);
                        n_fail  = (n_month == 4'd0);
                        n_phase = PH_YEAR_LEAD;
                    end
                    PH_YEAR_LEAD: begin
                        if (w_dig) begin
                            {n_fail, n_year} = w_add_year;
                            n_phase = PH_YEAR_DIG;
                        end else if (w_sign) begin
                            n_minus = (w_c == CH_MINUS);
                            n_phase = PH_YEAR_DIG;
                        end else if (!w_ws) begin
                            n_fail = 1'b1;
                        end
                    end
                    PH_YEAR_DIG: begin
                        if (w_dig) begin
                            {n_fail, n_year} = w_add_year;
                        end else begin
                            n_fail  = r_minus && (r_year != 14'd0);
                            n_minus = 1'b0;
                            n_taken = 1'b0;
                            n_phase = PH_HOUR_LEAD;
                            if (!n_fail) begin
                                if (w_dig) begin
                                    {n_fail, n_hour} = w_add_hour;
                                    n_phase = PH_HOUR_DIG;
                                end else if (w_sign) begin
                                    n_minus = (w_c == CH_MINUS);
                                    n_phase = PH_HOUR_DIG;
                                end else if (!w_ws) begin
                                    n_fail = 1'b1;
                                end
                            end
                        end
                    end
                    PH_HOUR_LEAD: begin
                        if (w_dig) begin
                            {n_fail, n_hour} = w_add_hour;
                            n_phase = PH_HOUR_DIG;
                        end else if (w_sign) begin
                            n_minus = (w_c == CH_MINUS);
                            n_phase = PH_HOUR_DIG;
                        end else if (!w_ws) begin
                            n_fail = 1'b1;
                        end
                    end
                    PH_HOUR_DIG: begin
                        if (w_dig) begin
                            {n_fail, n_hour} = w_add_hour;
                        end else begin
                            n_fail  = (r_minus && (r_hour != 7'd0)) || (w_c != CH_COLON);
                            n_minus = 1'b0;
                            n_taken = 1'b0;
                            if (w_c == CH_COLON) n_phase = PH_MIN_LEAD;
                        end
                    end
                    PH_MIN_LEAD: begin
                        if (w_ws) begin
                            n_taken = 1'b1;
                        end else if (w_dig) begin
                            {n_fail, n_min} = w_add_min;
                            n_phase = PH_MIN_DIG;
                        end else if (w_sign) begin
                            n_minus = (w_c == CH_MINUS);
                            n_phase = PH_MIN_DIG;
                        end else if (w_c == CH_COLON && r_taken) begin
                            n_fail  = r_minus && (r_min != 7'd0);
                            n_minus = 1'b0;
                            n_taken = 1'b0;
                            n_phase = PH_SEC_LEAD;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end
                    PH_MIN_DIG: begin
                        if (w_dig) begin
                            {n_fail, n_min} = w_add_min;
                        end else begin
                            n_fail  = (r_minus && (r_min != 7'd0)) || (w_c != CH_COLON);
                            n_minus = 1'b0;
                            n_taken = 1'b0;
                            if (w_c == CH_COLON) n_phase = PH_SEC_LEAD;
                        end
                    end
                    PH_SEC_LEAD: begin
                        if (w_dig) begin
                            {n_fail, n_sec} = w_add_sec;
                            n_phase = PH_SEC_DIG;
                        end else if (w_sign) begin
                            n_minus = (w_c == CH_MINUS);
                            n_phase = PH_SEC_DIG;
                        end else if (!w_ws) begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SEC_DIG: begin
                        if (w_dig) begin
                            {n_fail, n_sec} = w_add_sec;
                        end else begin
                            n_fail  = r_minus && (r_sec != 7'd0);
                            n_minus = 1'b0;
                            n_taken = 1'b0;
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // End of text, by a NUL byte or by the last character of the string.
        if (w_end || (o_push && !n_fail)) begin
            if (n_phase == PH_SEC_DIG) begin
                n_fail  = n_fail || (n_minus && (n_sec != 7'd0));
                n_minus = 1'b0;
                n_taken = 1'b0;
            end
            if (n_phase < PH_SEC_LEAD) n_fail = 1'b1;
            n_phase = PH_DONE;
        end

        w_ok = !n_fail && (n_year >= 14'd1970) && (n_year <= 14'(hdup_pkg::C_MAX_YEAR)) &&
               (n_month >= 4'd1) && (n_month <= 4'd12) && (n_day >= 7'd1) &&
               (n_day <= 7'd31) && (n_hour <= 7'd23) && (n_min <= 7'd59) && (n_sec <= 7'd60);

        o_rec.date_ok = w_ok;
        o_rec.year    = n_year;
        o_rec.month   = n_month;
        o_rec.day     = n_day[4:0];
        o_rec.hour    = n_hour[4:0];
        o_rec.minute  = n_min[5:0];
        o_rec.second  = n_sec[5:0];

        if (o_push) begin
            n_phase = PH_SKIP;
            n_day   = 7'd0;
            n_year  = 14'd0;
            n_hour  = 7'd0;
            n_min   = 7'd0;
            n_sec   = 7'd0;
            n_mon0  = 8'd0;
            n_mon1  = 8'd0;
            n_month = 4'd0;
            n_taken = 1'b0;
            n_minus = 1'b0;
            n_fail  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_day   <= 7'd0;
            r_year  <= 14'd0;
            r_hour  <= 7'd0;
            r_min   <= 7'd0;
            r_sec   <= 7'd0;
            r_mon0  <= 8'd0;
            r_mon1  <= 8'd0;
            r_month <= 4'd0;
            r_taken <= 1'b0;
            r_minus <= 1'b0;
            r_fail  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_day   <= n_day;
            r_year  <= n_year;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_mon0  <= n_mon0;
            r_mon1  <= n_mon1;
            r_month <= n_month;
            r_taken <= n_taken;
            r_minus <= n_minus;
            r_fail  <= n_fail;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hdup_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hdup_queue
// Short record queue between the parser and the converter.
// ============================================================================
module hdup_queue #(
    parameter int unsigned DEPTH = hdup_pkg::C_QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hdup_pkg::t_date_rec i_push_rec,
    input  wire logic                i_pop,
    output hdup_pkg::t_date_rec      o_pop_rec,
    output logic                     o_full,
    output logic                     o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    hdup_pkg::t_date_rec r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_rec = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hdup_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hdup_back
// Date converter: turns a parsed record into Unix seconds over a few steps
// and holds the result in an output register.
// ============================================================================
module hdup_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  wire hdup_pkg::t_date_rec i_rec,
    output logic                     o_pop,
    hdup_result_if.source            o_result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_YEAR = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // floor(x * RECIP100 / 2**19) equals floor(x / 100) for every 14-bit x.
    localparam logic [26:0] RECIP100 = 27'd5243;
    localparam int unsigned W_SEC    = hdup_pkg::W_SECONDS;

    logic [2:0]          r_state, n_state;
    hdup_pkg::t_date_rec r_rec;
    logic [13:0]         r_yd;
    logic [11:0]         r_n4;
    logic [7:0]          r_q100, r_q400, r_y100;
    logic [23:0]         r_year_days;
    logic                r_leap;
    logic [9:0]          r_mday;
    logic [16:0]         r_tod;
    logic [23:0]         r_days;
    logic                r_out_valid, n_out_valid;
    logic                r_out_ok;
    logic [W_SEC-1:0]    r_out_secs;

    logic [13:0] w_n;
    logic [26:0] w_p_n, w_p_n4, w_p_y;
    logic [13:0] w_hundreds;
    logic [40:0] w_secs;
    logic        w_load_out;

    assign w_n    = r_rec.year - 14'd1;
    assign w_p_n  = 27'(w_n) * RECIP100;
    assign w_p_n4 = 27'(w_n[13:2]) * RECIP100;
    assign w_p_y  = 27'(r_rec.year) * RECIP100;
    assign w_hundreds = 14'({6'd0, r_y100} * 14'd100);
    assign w_secs = 41'(r_days) * 41'd86400 + 41'(r_tod);

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || o_result.ready);

    assign o_result.valid        = r_out_valid;
    assign o_result.date_valid   = r_out_ok;
    assign o_result.unix_seconds = r_out_secs;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_DIV;
            ST_DIV:  n_state = ST_YEAR;
            ST_YEAR: n_state = ST_SUM;
            ST_SUM:  n_state = ST_OUT;
            ST_OUT:  if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = w_load_out || (r_out_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (r_state == ST_DIV) begin
            r_yd   <= r_rec.year - 14'd1970;
            r_n4   <= w_n[13:2];
            r_q100 <= w_p_n[26:19];
            r_q400 <= w_p_n4[26:19];
            r_y100 <= w_p_y[26:19];
        end
        if (r_state == ST_YEAR) begin
            r_year_days <= 24'(r_yd) * 24'd365 + 24'(r_n4) - 24'(r_q100) + 24'(r_q400)
                           - 24'd477;
            r_leap      <= (r_rec.year[1:0] == 2'b00) &&
                           ((r_rec.year != w_hundreds) || (r_y100[1:0] == 2'b00));
            r_mday      <= 10'(hdup_pkg::cum_days(r_rec.month)) + 10'(r_rec.day) - 10'd1;
            r_tod       <= 17'(r_rec.hour) * 17'd3600 + 17'(r_rec.minute) * 17'd60
                           + 17'(r_rec.second);
        end
        if (r_state == ST_SUM) begin
            r_days <= r_year_days + 24'(r_mday) + 24'(r_leap && (r_rec.month > 4'd2));
        end
        if (w_load_out) begin
            r_out_ok   <= r_rec.date_ok;
            r_out_secs <= r_rec.date_ok ? w_secs[W_SEC-1:0] : '0;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/http_date_to_unix_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// http_date_to_unix_parser
// RFC 1123 date string to Unix seconds, one character per transaction.
// ============================================================================
// The parser takes one character per cycle and keeps ready high as long as its
// record queue (QUEUE_DEPTH entries) has room. The transaction that carries the
// last character of a string places a checked record in the queue in that same
// cycle. The converter then works through each record in order: it pops the
// record from the queue, does three arithmetic steps (reciprocal divisions of
// the year, year and month day counts, their sum) and a multiply into the output
// register, which waits while a held result is not taken. It pops the next record
// only after that, so strings that arrive faster fill the queue and hold ready low.
module http_date_to_unix_parser #(
    parameter int unsigned QUEUE_DEPTH = hdup_pkg::C_QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    hdup_char_if.sink      i_char,
    hdup_result_if.source  o_result
);

    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;
    hdup_pkg::t_date_rec w_push_rec;
    hdup_pkg::t_date_rec w_pop_rec;

    hdup_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    hdup_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_rec (w_push_rec),
        .i_pop      (w_pop),
        .o_pop_rec  (w_pop_rec),
        .o_full     (w_full),
        .o_empty    (w_empty)
    );

    hdup_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_rec    (w_pop_rec),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    a_no_push_when_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_push |-> !w_full
    ) else $error("Record pushed into a full queue.");

    a_no_pop_when_empty : assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_pop |-> !w_empty
    ) else $error("Record popped from an empty queue.");

    a_last_char_queues : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_char.valid && i_char.ready && i_char.last_char) |=> !w_empty
    ) else $error("Last character transaction left no record in the queue.");

    a_invalid_is_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.date_valid) |-> (o_result.unix_seconds == '0)
    ) else $error("Invalid date reported with nonzero seconds.");

endmodule
`default_nettype wire
